// ===== rtl/core/rrq_pkg.sv =====
// Shared types and constants for the round-robin run queue.
package rrq_pkg;

    // Fixed field widths of the stream payload.
    localparam int TID_W    = 16;
    localparam int CNT_W    = 5;
    localparam int ID_OUT_W = 16;
    localparam int CMD_W    = 3;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 40;

    // Command codes carried in the low bits of the input transfer.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD     = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_NEXT    = 3'd2,
        CMD_SETRUN  = 3'd3,
        CMD_PREEMPT = 3'd4,
        CMD_SLEEP   = 3'd5,
        CMD_WAKE    = 3'd6
    } t_cmd;

    // Thread status stored next to each id.
    typedef enum logic [1:0] {
        ST_READY    = 2'd0,
        ST_RUNNING  = 2'd1,
        ST_SLEEPING = 2'd2
    } t_status;

endpackage

// ===== rtl/core/rrq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rrq_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/round_robin_run_queue.sv =====
// Round-robin run queue: thread slot table in RAM walked by a one-entry-per-cycle scanner.
// Add and early failures go from S_START straight to S_FIN; table scans visit at most the n
// occupied slots in S_SCAN, set by one RAM read per cycle. S_FIN waits for a free output.
// One command at a time: the next input is taken once the FSM is back in S_IDLE, also while
// the previous result still waits in the output register for the port.
// Reset: synchronous, active low; empties the table, cursor 0, id counter 1. RAM is not cleared.
module round_robin_run_queue #(
    parameter int MAX_SLOTS = 16,
    parameter int ID_WIDTH  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // Fields from bit 0: cmd[2:0], thread_id[18:3], zero pad.
    input  logic [rrq_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // Fields from bit 0: ok[0], id_out[16:1], used_slots[21:17], rdy_cnt[26:22],
    // run_cnt[31:27], slp_cnt[36:32], zero pad.
    output logic [rrq_pkg::OUT_W-1:0] m_axis_tdata
);
    import rrq_pkg::*;

    localparam int AW   = $clog2(MAX_SLOTS);
    localparam int CW   = $clog2(MAX_SLOTS + 1);
    localparam int WW   = ID_WIDTH + 2;
    localparam int CMPW = (ID_WIDTH > TID_W) ? ID_WIDTH : TID_W;

    typedef logic [CMPW-1:0] t_cmp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_FIN
    } t_state;

    // Control state.
    t_state              r_state, n_state;
    logic [CW-1:0]       r_total, n_total;
    logic [CW-1:0]       r_rdy, n_rdy;
    logic [CW-1:0]       r_run, n_run;
    logic [CW-1:0]       r_slp, n_slp;
    logic [ID_WIDTH-1:0] r_idc, n_idc;
    logic [AW-1:0]       r_cursor, n_cursor;
    logic                r_m_valid, n_m_valid;

    // Command and scan payload.
    t_cmd                r_cmd, n_cmd;
    logic [TID_W-1:0]    r_tid, n_tid;
    logic [CW-1:0]       r_left, n_left;
    logic [AW-1:0]       r_addr, n_addr;
    logic                r_chk, n_chk;
    logic [AW-1:0]       r_chk_idx, n_chk_idx;
    logic                r_found, n_found;
    logic [AW-1:0]       r_pos, n_pos;
    logic                r_ok, n_ok;
    logic [ID_OUT_W-1:0] r_id_res, n_id_res;
    logic [OUT_W-1:0]    r_m_data, n_m_data;

    // RAM ports.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WW-1:0]       ram_wdata;
    logic [WW-1:0]       ram_q;

    logic [ID_WIDTH-1:0] q_id;
    t_status             q_st;
    logic                id_hit;
    logic [AW-1:0]       last_idx;
    logic [CW-1:0]       total_dec;
    logic [AW-1:0]       rm_pos;

    rrq_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    // Fields of the entry read in the previous cycle.
    assign q_id      = ram_q[ID_WIDTH-1:0];
    assign q_st      = t_status'(ram_q[WW-1:ID_WIDTH]);
    assign id_hit    = (t_cmp'(q_id) == t_cmp'(r_tid));
    assign total_dec = r_total - CW'(1);
    assign last_idx  = AW'(total_dec);
    assign rm_pos    = r_found ? r_pos : r_chk_idx;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Sequencer: command decode, table scan and result formation.
    always_comb begin
        n_state   = r_state;
        n_total   = r_total;
        n_rdy     = r_rdy;
        n_run     = r_run;
        n_slp     = r_slp;
        n_idc     = r_idc;
        n_cursor  = r_cursor;
        n_m_valid = r_m_valid;
        n_cmd     = r_cmd;
        n_tid     = r_tid;
        n_left    = r_left;
        n_addr    = r_addr;
        n_chk     = 1'b0;
        n_chk_idx = r_addr;
        n_found   = r_found;
        n_pos     = r_pos;
        n_ok      = r_ok;
        n_id_res  = r_id_res;
        n_m_data  = r_m_data;
        ram_we    = 1'b0;
        ram_waddr = r_chk_idx;
        ram_wdata = ram_q;

        // The consumer took the waiting result.
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd   = t_cmd'(s_axis_tdata[CMD_W-1:0]);
                    n_tid   = s_axis_tdata[CMD_W+TID_W-1:CMD_W];
                    n_state = S_START;
                end
            end

            S_START: begin
                n_ok     = 1'b0;
                n_id_res = '0;
                n_found  = 1'b0;
                n_left   = r_total;
                n_addr   = (r_cmd == CMD_NEXT) ? r_cursor : '0;
                n_state  = S_FIN;
                unique case (r_cmd)
                    CMD_ADD: begin
                        if (r_total < CW'(MAX_SLOTS)) begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(r_total);
                            ram_wdata = {ST_READY, r_idc};
                            n_total   = r_total + CW'(1);
                            n_rdy     = r_rdy + CW'(1);
                            n_idc     = r_idc + ID_WIDTH'(1);
                            n_ok      = 1'b1;
                            n_id_res  = ID_OUT_W'(r_idc);
                        end
                    end
                    CMD_NEXT: begin
                        if (r_rdy != '0) begin
                            n_state = S_SCAN;
                        end
                    end
                    CMD_PREEMPT: begin
                        if (r_run != '0) begin
                            n_state = S_SCAN;
                        end
                    end
                    CMD_REMOVE, CMD_SETRUN, CMD_SLEEP, CMD_WAKE: begin
                        if (r_total != '0) begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end

            S_SCAN: begin
                // Issue the next read; the address wraps at the last occupied slot.
                if (r_left != '0) begin
                    n_chk     = 1'b1;
                    n_chk_idx = r_addr;
                    n_left    = r_left - CW'(1);
                    n_addr    = (r_addr == last_idx) ? '0 : r_addr + AW'(1);
                end
                // Check the entry returned by the RAM.
                if (r_chk) begin
                    unique case (r_cmd)
                        CMD_REMOVE: begin
                            if (r_found) begin
                                // Close the gap: move each later entry down by one.
                                ram_we    = 1'b1;
                                ram_waddr = r_chk_idx - AW'(1);
                                ram_wdata = ram_q;
                            end else if (id_hit) begin
                                n_found = 1'b1;
                                n_pos   = r_chk_idx;
                                unique case (q_st)
                                    ST_READY:    n_rdy = n_rdy - CW'(1);
                                    ST_RUNNING:  n_run = n_run - CW'(1);
                                    ST_SLEEPING: n_slp = n_slp - CW'(1);
                                    default:     n_rdy = n_rdy;
                                endcase
                            end
                            if (r_left == '0) begin
                                n_state = S_FIN;
                                if (r_found || id_hit) begin
                                    n_ok    = 1'b1;
                                    n_total = total_dec;
                                    if (r_cursor != '0 && CW'(r_cursor) >= total_dec) begin
                                        n_cursor = '0;
                                    end else if (rm_pos < r_cursor) begin
                                        n_cursor = r_cursor - AW'(1);
                                    end
                                end
                            end
                        end
                        CMD_SETRUN, CMD_SLEEP: begin
                            if (id_hit) begin
                                ram_we    = 1'b1;
                                ram_wdata = {(r_cmd == CMD_SETRUN) ? ST_RUNNING : ST_SLEEPING,
                                             q_id};
                                unique case (q_st)
                                    ST_READY:    n_rdy = n_rdy - CW'(1);
                                    ST_RUNNING:  n_run = n_run - CW'(1);
                                    ST_SLEEPING: n_slp = n_slp - CW'(1);
                                    default:     n_rdy = n_rdy;
                                endcase
                                if (r_cmd == CMD_SETRUN) begin
                                    n_run = n_run + CW'(1);
                                end else begin
                                    n_slp = n_slp + CW'(1);
                                end
                                n_ok    = 1'b1;
                                n_state = S_FIN;
                            end else if (r_left == '0) begin
                                n_state = S_FIN;
                            end
                        end
                        CMD_WAKE: begin
                            // The first slot with the id decides, asleep or not.
                            if (id_hit) begin
                                if (q_st == ST_SLEEPING) begin
                                    ram_we    = 1'b1;
                                    ram_wdata = {ST_READY, q_id};
                                    n_slp     = r_slp - CW'(1);
                                    n_rdy     = r_rdy + CW'(1);
                                    n_ok      = 1'b1;
                                end
                                n_state = S_FIN;
                            end else if (r_left == '0) begin
                                n_state = S_FIN;
                            end
                        end
                        CMD_PREEMPT: begin
                            if (q_st == ST_RUNNING) begin
                                ram_we    = 1'b1;
                                ram_wdata = {ST_READY, q_id};
                                n_run     = r_run - CW'(1);
                                n_rdy     = r_rdy + CW'(1);
                                n_ok      = 1'b1;
                                n_state   = S_FIN;
                            end else if (r_left == '0) begin
                                n_state = S_FIN;
                            end
                        end
                        CMD_NEXT: begin
                            if (q_st == ST_READY) begin
                                n_cursor = (r_chk_idx == last_idx) ? '0
                                                                   : r_chk_idx + AW'(1);
                                n_id_res = ID_OUT_W'(q_id);
                                n_ok     = 1'b1;
                                n_state  = S_FIN;
                            end else if (r_left == '0) begin
                                n_state = S_FIN;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            S_FIN: begin
                // Load the output register once it is free.
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {3'b000, CNT_W'(r_slp), CNT_W'(r_run), CNT_W'(r_rdy),
                                 CNT_W'(r_total), r_id_res, r_ok};
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_tid     <= n_tid;
        r_left    <= n_left;
        r_addr    <= n_addr;
        r_chk     <= n_chk;
        r_chk_idx <= n_chk_idx;
        r_found   <= n_found;
        r_pos     <= n_pos;
        r_ok      <= n_ok;
        r_id_res  <= n_id_res;
        r_m_data  <= n_m_data;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_rdy     <= '0;
            r_run     <= '0;
            r_slp     <= '0;
            r_idc     <= ID_WIDTH'(1);
            r_cursor  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_rdy     <= n_rdy;
            r_run     <= n_run;
            r_slp     <= n_slp;
            r_idc     <= n_idc;
            r_cursor  <= n_cursor;
            r_m_valid <= n_m_valid;
        end
    end

    // The status counts add up to the occupancy whenever the sequencer is idle.
    a_counts_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
        ((CW+2)'(r_rdy) + (CW+2)'(r_run) + (CW+2)'(r_slp) == (CW+2)'(r_total)))
        else $error("status counts do not add up to the occupancy");

    // Occupancy never exceeds the table size.
    a_total_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(MAX_SLOTS))
        else $error("occupancy above table size");

    // The cursor points inside the occupied range or rests at zero.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cursor == '0 || CW'(r_cursor) < r_total))
        else $error("cursor outside occupied slots");

    // A result is formed only when leaving the final state.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_m_valid)) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside the final state");

endmodule
